/* rtl/lfdsa_pkg.sv */
package lfdsa_pkg;

	localparam int unsigned DEADLINE_W = 11;
	localparam int unsigned TAG_W      = 24;
	localparam int unsigned SLOT_W     = 10;

	typedef enum logic {
		CMD_PLACE = 1'b0,
		CMD_QUERY = 1'b1
	} cmd_t;

	typedef enum logic [1:0] {
		STATUS_PLACED = 2'd0,
		STATUS_NOFIT  = 2'd1,
		STATUS_FULL   = 2'd2,
		STATUS_FREE   = 2'd3
	} status_t;

	typedef struct packed {
		cmd_t                  command;
		logic [DEADLINE_W-1:0] deadline;
		logic [TAG_W-1:0]      job_id;
	} job_item_t;

	typedef struct packed {
		status_t           status;
		logic [SLOT_W-1:0] slot;
		logic [TAG_W-1:0]  job_id_out;
	} result_item_t;

endpackage

/* rtl/lfdsa_stream_if.sv */
interface lfdsa_stream_if #(
	parameter type T = logic
) ();
	logic valid;
	logic ready;
	T     data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

/* rtl/lfdsa_ram.sv */
module lfdsa_ram #(
	parameter int unsigned WIDTH = 11,
	parameter int unsigned DEPTH = 1025
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule

/* rtl/latest_free_deadline_slot_allocator_top.sv */
// Channel | Modport | Payload        | Moves
// --------+---------+----------------+-------------------------------------------
// job     | sink    | job_item_t     | one place or query item in
// result  | source  | result_item_t  | one status item out per job item
//
// Finds: a find walks up the parent chain to the root, then walks it a second
//   time to compress the path. A query runs one find; a placement runs two
//   (deadline, then slot-1), or only the first when nothing fits. Each item is
//   accepted, then its result is handed to the output register.
// Reset: a clearing pass writes every parent entry with its own index, one
//   entry per cycle; job.ready stays low until it ends.
// Stalls: the result sits in an output register; a new item is taken while it
//   waits, and the next result is held until the register frees up.
module latest_free_deadline_slot_allocator_top #(
	parameter int unsigned NUM_SLOTS = 1024
) (
	input  logic          clk,
	input  logic          arst_n,
	lfdsa_stream_if.sink   job,
	lfdsa_stream_if.source result
);
	import lfdsa_pkg::*;

	// index 0 is the "no slot" sentinel, 1..NUM_SLOTS are real slots
	localparam int unsigned IW = $clog2(NUM_SLOTS + 1);
	localparam logic [IW-1:0] LAST = IW'(NUM_SLOTS);
	localparam logic [IW-1:0] ONE  = IW'(1);

	typedef enum logic [4:0] {
		ST_CLEAR = 5'b00001,
		ST_IDLE  = 5'b00010,
		ST_FIND  = 5'b00100,  // walk parents up to the root
		ST_COMP  = 5'b01000,  // walk again, pointing each node at the root
		ST_DONE  = 5'b10000
	} state_t;

	state_t       state_q;
	logic [IW-1:0] clr_q;
	logic [IW-1:0] cur_q;    // current node of either walk
	logic [IW-1:0] start_q;  // where the current find began
	logic [IW-1:0] root_q;   // root found by the first walk
	logic [IW-1:0] s_q;      // slot chosen by the deadline find
	logic          pass_q;   // 0: deadline find, 1: find of slot-1
	cmd_t          cmd_q;
	logic [TAG_W-1:0] tag_q;
	result_item_t  res_q;
	result_item_t  out_q;
	logic          out_valid_q;

	// parent store port
	logic          ram_we;
	logic [IW-1:0] ram_waddr;
	logic [IW-1:0] ram_wdata;
	logic [IW-1:0] ram_raddr;
	logic [IW-1:0] ram_rd;

	logic [IW-1:0] dl_idx;
	logic [IW-1:0] start_idx;
	logic          hit;

	lfdsa_ram #(
		.WIDTH(IW),
		.DEPTH(NUM_SLOTS + 1)
	) u_parent (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.raddr(ram_raddr),
		.rdata(ram_rd)
	);

	// deadlines past the last slot saturate
	always_comb begin
		if (32'(job.data.deadline) > NUM_SLOTS) begin
			dl_idx = LAST;
		end else begin
			dl_idx = IW'(job.data.deadline);
		end
		start_idx = (job.data.command == CMD_QUERY) ? LAST : dl_idx;
	end

	// ram_rd holds parent[cur_q] in FIND and COMP; a self-link marks the root
	assign hit = (ram_rd == cur_q);

	assign job.ready    = (state_q == ST_IDLE);
	assign result.valid = out_valid_q;
	assign result.data  = out_q;

	// store addressing: each step issues the read of the next node at once,
	// so the walk advances one node per cycle
	always_comb begin
		ram_we    = 1'b0;
		ram_waddr = cur_q;
		ram_wdata = root_q;
		ram_raddr = cur_q;
		unique case (state_q)
			ST_CLEAR: begin
				ram_we    = 1'b1;
				ram_waddr = clr_q;
				ram_wdata = clr_q;
			end
			ST_IDLE: begin
				ram_raddr = start_idx;
			end
			ST_FIND: begin
				ram_raddr = hit ? start_q : ram_rd;
			end
			ST_COMP: begin
				if (!hit) begin
					ram_we    = 1'b1;
					ram_raddr = ram_rd;
				end else if (pass_q) begin
					// link the chosen slot to the latest free slot before it
					ram_we    = 1'b1;
					ram_waddr = s_q;
				end else begin
					ram_raddr = root_q - ONE;
				end
			end
			ST_DONE: begin
				ram_raddr = cur_q;
			end
			default: begin
				ram_raddr = cur_q;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_CLEAR;
			clr_q       <= '0;
			cur_q       <= '0;
			start_q     <= '0;
			root_q      <= '0;
			s_q         <= '0;
			pass_q      <= 1'b0;
			cmd_q       <= CMD_PLACE;
			tag_q       <= '0;
			res_q       <= '0;
			out_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			// in DONE the output register is reloaded below instead
			if (out_valid_q && result.ready && state_q != ST_DONE) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_CLEAR: begin
					clr_q <= clr_q + ONE;
					if (clr_q == LAST) begin
						state_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					if (job.valid) begin
						cmd_q   <= job.data.command;
						tag_q   <= job.data.job_id;
						cur_q   <= start_idx;
						start_q <= start_idx;
						pass_q  <= 1'b0;
						state_q <= ST_FIND;
					end
				end
				ST_FIND: begin
					if (hit) begin
						root_q  <= cur_q;
						cur_q   <= start_q;
						state_q <= ST_COMP;
					end else begin
						cur_q <= ram_rd;
					end
				end
				ST_COMP: begin
					if (!hit) begin
						cur_q <= ram_rd;
					end else if (cmd_q == CMD_QUERY) begin
						res_q.status     <= (root_q != '0) ? STATUS_FREE : STATUS_FULL;
						res_q.slot       <= '0;
						res_q.job_id_out <= '0;
						state_q          <= ST_DONE;
					end else if (pass_q) begin
						res_q.status     <= STATUS_PLACED;
						res_q.slot       <= SLOT_W'(s_q - ONE);
						res_q.job_id_out <= tag_q;
						state_q          <= ST_DONE;
					end else if (root_q == '0) begin
						res_q.status     <= STATUS_NOFIT;
						res_q.slot       <= '0;
						res_q.job_id_out <= tag_q;
						state_q          <= ST_DONE;
					end else begin
						s_q     <= root_q;
						cur_q   <= root_q - ONE;
						start_q <= root_q - ONE;
						pass_q  <= 1'b1;
						state_q <= ST_FIND;
					end
				end
				ST_DONE: begin
					if (!out_valid_q || result.ready) begin
						out_q       <= res_q;
						out_valid_q <= 1'b1;
						state_q     <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end
endmodule

/* rtl/lfdsa_checker.sv */
module lfdsa_checker (
	input logic                            clk,
	input logic                            arst_n,
	input logic                            job_valid,
	input logic                            job_ready,
	input logic                            res_valid,
	input logic                            res_ready,
	input lfdsa_pkg::status_t              res_status,
	input logic [lfdsa_pkg::SLOT_W-1:0]    res_slot,
	input logic [lfdsa_pkg::TAG_W-1:0]     res_tag
);
	import lfdsa_pkg::*;

	logic       acc_in;
	logic       acc_out;
	logic [1:0] cnt_q;  // items taken whose result is not yet delivered

	assign acc_in  = job_valid && job_ready;
	assign acc_out = res_valid && res_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else begin
			cnt_q <= cnt_q + 2'(acc_in) - 2'(acc_out);
		end
	end

	// busy after every accepted item
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		acc_in |=> !job_ready)
		else $error("job.ready high right after an accept");

	// no result without an item behind it
	a_no_spurious: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid |-> cnt_q != 2'd0)
		else $error("result with no outstanding item");

	// at most one finished result may wait when a new item is taken
	a_depth: assert property (@(posedge clk) disable iff (!arst_n)
		acc_in |-> cnt_q <= 2'd1)
		else $error("item taken with two items outstanding");

	// queries and failed placements carry no slot; queries carry no tag
	a_fields: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && (res_status == STATUS_FULL || res_status == STATUS_FREE
			|| res_status == STATUS_NOFIT)
		|-> res_slot == '0
			&& (res_status == STATUS_NOFIT || res_tag == '0))
		else $error("result fields inconsistent with status");

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_ready |=> res_valid && $stable(res_status)
			&& $stable(res_slot) && $stable(res_tag))
		else $error("stalled result changed");
endmodule

bind latest_free_deadline_slot_allocator_top lfdsa_checker u_chk (
	.clk       (clk),
	.arst_n    (arst_n),
	.job_valid (job.valid),
	.job_ready (job.ready),
	.res_valid (result.valid),
	.res_ready (result.ready),
	.res_status(result.data.status),
	.res_slot  (result.data.slot),
	.res_tag   (result.data.job_id_out)
);

/* tb/sv/tb_latest_free_deadline_slot_allocator_top.sv */
import lfdsa_pkg::*;

// Scoreboard: mirrors the parent store and queues one outcome per accepted item.
class slot_scoreboard;
	int unsigned           n_slots;
	logic [DEADLINE_W-1:0] slot_parent [];
	result_item_t          outcome_q [$];
	int unsigned           errors;

	function new(int unsigned n);
		n_slots     = n;
		slot_parent = new[n + 1];
		for (int i = 0; i <= n; i++) begin
			slot_parent[i] = DEADLINE_W'(i);
		end
		errors = 0;
	endfunction

	function int unsigned clamp_slot(int unsigned v);
		return (v > n_slots) ? n_slots : v;
	endfunction

	// Latest free slot at or before start, 0 if none; compresses the path.
	function int unsigned latest_free(int unsigned start);
		int unsigned root;
		int unsigned walk;
		int unsigned next;
		root = clamp_slot(start);
		walk = root;
		while (slot_parent[root] != root) begin
			root = clamp_slot(slot_parent[root]);
		end
		while (slot_parent[walk] != walk) begin
			next = clamp_slot(slot_parent[walk]);
			slot_parent[walk] = DEADLINE_W'(root);
			walk = next;
		end
		return root;
	endfunction

	function void note_job(job_item_t it);
		result_item_t r;
		int unsigned  s;
		r = '0;
		if (it.command == CMD_QUERY) begin
			r.status = (latest_free(n_slots) != 0) ? STATUS_FREE : STATUS_FULL;
		end else begin
			s = latest_free(it.deadline);
			if (s == 0) begin
				r.status = STATUS_NOFIT;
			end else begin
				// taking slot s links it to the next free one below
				slot_parent[s] = DEADLINE_W'(latest_free(s - 1));
				r.status = STATUS_PLACED;
				r.slot   = SLOT_W'(s - 1);
			end
			r.job_id_out = it.job_id;
		end
		outcome_q = {outcome_q, r};
	endfunction

	function void check_outcome(result_item_t got);
		result_item_t want;
		if (outcome_q.size() == 0) begin
			errors++;
			$display("%0t: result with nothing outstanding: status %0d slot %0d job %h",
				$time, got.status, got.slot, got.job_id_out);
			return;
		end
		want = outcome_q.pop_front();
		if (got.status !== want.status) begin
			errors++;
			$display("%0t: status mismatch: expected %0d actual %0d",
				$time, want.status, got.status);
		end
		if (got.slot !== want.slot) begin
			errors++;
			$display("%0t: slot mismatch: expected %0d actual %0d",
				$time, want.slot, got.slot);
		end
		if (got.job_id_out !== want.job_id_out) begin
			errors++;
			$display("%0t: job_id_out mismatch: expected %h actual %h",
				$time, want.job_id_out, got.job_id_out);
		end
	endfunction
endclass

module tb_latest_free_deadline_slot_allocator_top;

	localparam int unsigned SLOTS       = 1024;
	localparam int unsigned RAND_ITEMS  = 780;
	// The limit covers a slow correct run (clear pass, ~800 items, long gaps
	// and stalls) several times over.
	localparam int unsigned CYCLE_LIMIT = 1500000;
	localparam int unsigned TAIL_CYCLES = 20;

	logic clk;
	logic arst_n;

	lfdsa_stream_if #(.T(job_item_t))    job_ch ();
	lfdsa_stream_if #(.T(result_item_t)) result_ch ();

	latest_free_deadline_slot_allocator_top #(
		.NUM_SLOTS(SLOTS)
	) i_dut (
		.clk   (clk),
		.arst_n(arst_n),
		.job   (job_ch),
		.result(result_ch)
	);

	slot_scoreboard sb;

	int unsigned cycle_count = 0;
	bit          no_idle     = 0;  // when set, neither side inserts gaps

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Watchdog: a hang anywhere ends the run as a failure.
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("tb_latest_free_deadline_slot_allocator_top failed");
			$finish;
		end
	end

	// Monitor: sampled at the edge, before any nonblocking update lands.
	// The result is checked first; it always belongs to an older item.
	always @(posedge clk) begin
		if (arst_n) begin
			if (result_ch.valid && result_ch.ready) begin
				sb.check_outcome(result_ch.data);
			end
			if (job_ch.valid && job_ch.ready) begin
				sb.note_job(job_ch.data);
			end
		end
	end

	// Gap length: mostly none, some short, a few long.
	function automatic int unsigned gap_len();
		int unsigned r;
		r = $urandom_range(0, 99);
		if (no_idle || r < 60) begin
			return 0;
		end else if (r < 90) begin
			return $urandom_range(1, 3);
		end else if (r < 97) begin
			return $urandom_range(4, 10);
		end
		return $urandom_range(20, 60);
	endfunction

	// Result side: bursts of ready, broken by random stalls.
	initial begin
		int unsigned stall;
		result_ch.ready <= 1'b0;
		@(posedge clk);
		forever begin
			result_ch.ready <= 1'b1;
			repeat ($urandom_range(1, 20)) @(posedge clk);
			stall = gap_len();
			if (stall > 0) begin
				result_ch.ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
		end
	end

	// Offer one item and hold it until the block takes it. valid is only
	// dropped when a gap follows, so back-to-back items keep it high.
	task automatic send_job(cmd_t cmd, logic [DEADLINE_W-1:0] dl, logic [TAG_W-1:0] id);
		job_item_t   it;
		int unsigned gap;
		it.command  = cmd;
		it.deadline = dl;
		it.job_id   = id;
		job_ch.valid <= 1'b1;
		job_ch.data  <= it;
		do begin
			@(posedge clk);
		end while (!job_ch.ready);
		gap = gap_len();
		if (gap > 0) begin
			job_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	// Random deadline: exact top, zero, saturated, a tight low window that
	// fills fast and then refuses, and anything in range.
	function automatic logic [DEADLINE_W-1:0] pick_deadline();
		int unsigned r;
		r = $urandom_range(0, 99);
		if (r < 8) begin
			return '0;
		end else if (r < 18) begin
			return DEADLINE_W'(SLOTS);
		end else if (r < 30) begin
			return DEADLINE_W'($urandom_range(SLOTS + 1, 2047));
		end else if (r < 55) begin
			return DEADLINE_W'($urandom_range(1, 64));
		end
		return DEADLINE_W'($urandom_range(1, SLOTS));
	endfunction

	initial begin
		sb = new(SLOTS);
		arst_n        <= 1'b0;
		job_ch.valid  <= 1'b0;
		job_ch.data   <= '0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;

		// Directed: empty store, zero deadline, first slot taken twice, top
		// deadline, saturated deadlines, tag extremes, nothing left below.
		send_job(CMD_QUERY, 11'h7FF, 24'hFFFFFF);
		send_job(CMD_PLACE, 11'd0, 24'h000001);
		send_job(CMD_PLACE, 11'd1, 24'h000002);
		send_job(CMD_PLACE, 11'd1, 24'h000003);
		send_job(CMD_PLACE, 11'd1024, 24'h000004);
		send_job(CMD_PLACE, 11'd1024, 24'h000005);
		send_job(CMD_PLACE, 11'h7FF, 24'h000006);
		send_job(CMD_PLACE, 11'd1025, 24'h000007);
		send_job(CMD_PLACE, 11'd2, 24'hFFFFFF);
		send_job(CMD_PLACE, 11'd3, 24'h000000);
		send_job(CMD_PLACE, 11'd3, 24'h123456);
		send_job(CMD_QUERY, 11'd0, 24'h000000);
		send_job(CMD_PLACE, 11'h555, 24'hAAAAAA);
		send_job(CMD_PLACE, 11'h2AA, 24'h555555);
		send_job(CMD_PLACE, 11'd1023, 24'h800000);
		send_job(CMD_PLACE, 11'd1022, 24'h7FFFFF);
		send_job(CMD_PLACE, 11'd1024, 24'h00FF00);
		send_job(CMD_QUERY, 11'h555, 24'hABCDEF);

		// Random mix; a stretch in the middle runs with no gaps at all.
		for (int n = 0; n < RAND_ITEMS; n++) begin
			no_idle = (n >= 300 && n < 400);
			if ($urandom_range(0, 99) < 12) begin
				send_job(CMD_QUERY, DEADLINE_W'($urandom), TAG_W'($urandom));
			end else begin
				send_job(CMD_PLACE, pick_deadline(), TAG_W'($urandom));
			end
		end
		no_idle = 0;

		// Closing probes: query, lowest and top deadline, query.
		send_job(CMD_QUERY, 11'd0, 24'h000000);
		send_job(CMD_PLACE, 11'd1, 24'h0F0F0F);
		send_job(CMD_PLACE, 11'd1024, 24'hF0F0F0);
		send_job(CMD_QUERY, 11'h7FF, 24'hFFFFFF);

		job_ch.valid <= 1'b0;
		// let the monitor note the last item before watching the queue
		@(posedge clk);
		while (sb.outcome_q.size() != 0) begin
			@(posedge clk);
		end
		repeat (TAIL_CYCLES) @(posedge clk);

		if (sb.errors == 0 && sb.outcome_q.size() == 0) begin
			$display("tb_latest_free_deadline_slot_allocator_top passed");
		end else begin
			$display("tb_latest_free_deadline_slot_allocator_top failed");
		end
		$finish;
	end

endmodule

/* files.f */
rtl/lfdsa_pkg.sv
rtl/lfdsa_stream_if.sv
rtl/lfdsa_ram.sv
rtl/latest_free_deadline_slot_allocator_top.sv
rtl/lfdsa_checker.sv
tb/sv/tb_latest_free_deadline_slot_allocator_top.sv
